// ===== rtl/core/tgpg_pkg.sv =====
// Shared constants, types and the 5x7 font table for the glyph pixel generator.
// Used by the interfaces, the controller, the datapath and the top level.
package tgpg_pkg;

    localparam int COORD_BITS  = 10;
    localparam int CODE_BITS   = 8;
    localparam int COLOR_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam int CELL_W      = 6;
    localparam int CELL_H      = 8;
    localparam int GLYPH_W     = 5;
    localparam int LINE_STEP   = 9;
    localparam int GLYPH_COUNT = 85;
    localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);
    localparam int COL_BITS    = $clog2(CELL_W);
    localparam int ROW_BITS    = $clog2(CELL_H);

    localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_PANEL_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [COORD_BITS-1:0] PANEL_RESET = COORD_BITS'(240);

    localparam logic [CODE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CODE_BITS-1:0] CHAR_QMARK   = 8'h3F;
    localparam logic [CODE_BITS-1:0] CHAR_FIRST   = 8'h20;
    localparam logic [CODE_BITS-1:0] CHAR_LAST    = 8'h7A;
    localparam logic [CODE_BITS-1:0] GAP_FIRST    = 8'h5B;
    localparam logic [CODE_BITS-1:0] GAP_LAST     = 8'h60;
    localparam logic [CODE_BITS-1:0] LOWER_FIRST  = 8'h61;
    localparam logic [CODE_BITS-1:0] LOWER_OFFSET = 8'h26;

    typedef struct packed {
        logic load;
        logic line_feed;
        logic set_stop;
        logic latch_glyph;
        logic advance;
        logic step_x;
    } tgpg_cmd_t;

    typedef struct packed {
        logic stopped;
        logic is_newline;
        logic wrap;
        logic too_tall;
        logic last;
    } tgpg_stat_t;

    // Column c of a glyph sits in bits [39-8c -: 8]; bit r of that byte is row r.
    localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00,
        40'h14_7F_14_7F_14, 40'h24_2A_7F_2A_12, 40'h23_13_08_64_62,
        40'h36_49_55_22_50, 40'h00_05_03_00_00, 40'h00_1C_22_41_00,
        40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00,
        40'h20_10_08_04_02, 40'h3E_51_49_45_3E, 40'h00_42_7F_40_00,
        40'h42_61_51_49_46, 40'h21_41_45_4B_31, 40'h18_14_12_7F_10,
        40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00,
        40'h00_56_36_00_00, 40'h08_14_22_41_00, 40'h14_14_14_14_14,
        40'h00_41_22_14_08, 40'h02_01_51_09_06, 40'h32_49_79_41_3E,
        40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01,
        40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
        40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
        40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
        40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
        40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
        40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h20_54_54_54_78,
        40'h7F_48_44_44_38, 40'h38_44_44_44_20, 40'h38_44_44_48_7F,
        40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
        40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00,
        40'h7F_10_28_44_00, 40'h00_41_7F_40_00, 40'h7C_04_18_04_78,
        40'h7C_08_04_04_78, 40'h38_44_44_44_38, 40'h7C_14_14_14_08,
        40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
        40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C,
        40'h3C_40_30_40_3C, 40'h44_28_10_28_44, 40'h0C_50_50_50_3C,
        40'h44_64_54_4C_44
    };

    function automatic logic [GLYPH_IDX_BITS-1:0] rom_index(input logic [CODE_BITS-1:0] code);
        logic [CODE_BITS-1:0] c;
        c = code;
        if (c < CHAR_FIRST || c > CHAR_LAST || c inside {[GAP_FIRST:GAP_LAST]})
        begin
            c = CHAR_QMARK;
        end
        if (c >= LOWER_FIRST)
        begin
            return GLYPH_IDX_BITS'(c - LOWER_OFFSET);
        end
        return GLYPH_IDX_BITS'(c - CHAR_FIRST);
    endfunction

endpackage

// ===== rtl/core/tgpg_in_if.sv =====
// Character request channel of the glyph pixel generator.
// Depends on tgpg_pkg for field widths.
interface tgpg_in_if;
    logic                                valid;
    logic                                ready;
    logic [tgpg_pkg::CODE_BITS-1:0]      char_code;
    logic                                new_string;
    logic [tgpg_pkg::COORD_BITS-1:0]     start_x;
    logic [tgpg_pkg::COORD_BITS-1:0]     start_y;
    logic [tgpg_pkg::COLOR_BITS-1:0]     fg_color;
    logic [tgpg_pkg::COLOR_BITS-1:0]     bg_color;

    modport source (output valid, char_code, new_string, start_x, start_y, fg_color, bg_color,
                    input ready);
    modport sink   (input valid, char_code, new_string, start_x, start_y, fg_color, bg_color,
                    output ready);
endinterface

// ===== rtl/core/tgpg_out_if.sv =====
// Pixel request channel of the glyph pixel generator.
// Depends on tgpg_pkg for field widths.
interface tgpg_out_if;
    logic                                valid;
    logic                                ready;
    logic [tgpg_pkg::COORD_BITS-1:0]     pixel_x;
    logic [tgpg_pkg::COORD_BITS-1:0]     pixel_y;
    logic [tgpg_pkg::COLOR_BITS-1:0]     pixel_color;
    logic                                last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== rtl/core/tgpg_cfg_if.sv =====
// Register write channel of the glyph pixel generator.
// Depends on tgpg_pkg for index and data widths.
interface tgpg_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [tgpg_pkg::CFG_IDX_BITS-1:0]     index;
    logic [tgpg_pkg::COORD_BITS-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tgpg_datapath.sv =====
// Datapath: panel registers, text cursor, glyph latch and pixel counters.
// Driven by tgpg_ctrl through tgpg_pkg::tgpg_cmd_t; depends on tgpg_pkg.
module tgpg_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tgpg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tgpg_pkg::COORD_BITS-1:0]    cfg_data,
    input  logic [tgpg_pkg::CODE_BITS-1:0]     char_code,
    input  logic                               new_string,
    input  logic [tgpg_pkg::COORD_BITS-1:0]    start_x,
    input  logic [tgpg_pkg::COORD_BITS-1:0]    start_y,
    input  logic [tgpg_pkg::COLOR_BITS-1:0]    fg_color,
    input  logic [tgpg_pkg::COLOR_BITS-1:0]    bg_color,
    input  tgpg_pkg::tgpg_cmd_t                cmd,
    output tgpg_pkg::tgpg_stat_t               stat,
    output logic [tgpg_pkg::COORD_BITS-1:0]    pixel_x,
    output logic [tgpg_pkg::COORD_BITS-1:0]    pixel_y,
    output logic [tgpg_pkg::COLOR_BITS-1:0]    pixel_color,
    output logic                               last_pixel
);
    localparam int CB = tgpg_pkg::COORD_BITS;
    localparam logic [CB:0] COORD_MAX = {1'b0, {CB{1'b1}}};

    logic [CB-1:0] width_reg, width_next;
    logic [CB-1:0] height_reg, height_next;
    logic [CB-1:0] cursor_x_reg, cursor_x_next;
    logic [CB-1:0] cursor_y_reg, cursor_y_next;
    logic [CB-1:0] line_x_reg, line_x_next;
    logic          stopped_reg, stopped_next;
    logic [tgpg_pkg::CODE_BITS-1:0]  code_reg, code_next;
    logic [tgpg_pkg::COLOR_BITS-1:0] fg_reg, fg_next;
    logic [tgpg_pkg::COLOR_BITS-1:0] bg_reg, bg_next;
    logic [39:0]   glyph_reg, glyph_next;
    logic [tgpg_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [tgpg_pkg::COL_BITS-1:0] col_reg, col_next;

    logic [CB:0]   y_step;
    logic [CB:0]   x_step;
    logic [CB-1:0] y_sat;
    logic [CB-1:0] x_sat;
    logic          col_end;
    logic [7:0]    col_byte;

    assign y_step = {1'b0, cursor_y_reg} + (CB+1)'(tgpg_pkg::LINE_STEP);
    assign x_step = {1'b0, cursor_x_reg} + (CB+1)'(tgpg_pkg::CELL_W);
    assign y_sat  = (y_step > COORD_MAX) ? {CB{1'b1}} : y_step[CB-1:0];
    assign x_sat  = (x_step > COORD_MAX) ? {CB{1'b1}} : x_step[CB-1:0];
    assign col_end = (col_reg == tgpg_pkg::COL_BITS'(tgpg_pkg::CELL_W - 1));

    assign stat.stopped    = stopped_reg;
    assign stat.is_newline = (code_reg == tgpg_pkg::CHAR_NEWLINE);
    assign stat.wrap       = (x_step > {1'b0, width_reg});
    assign stat.too_tall   = (({1'b0, cursor_y_reg} + (CB+1)'(tgpg_pkg::CELL_H))
                              > {1'b0, height_reg});
    assign stat.last       = col_end && (row_reg == tgpg_pkg::ROW_BITS'(tgpg_pkg::CELL_H - 1));

    always_comb
    begin
        case (col_reg)
            3'd0:    col_byte = glyph_reg[39:32];
            3'd1:    col_byte = glyph_reg[31:24];
            3'd2:    col_byte = glyph_reg[23:16];
            3'd3:    col_byte = glyph_reg[15:8];
            3'd4:    col_byte = glyph_reg[7:0];
            default: col_byte = 8'h00;
        endcase
    end

    assign pixel_x     = cursor_x_reg + CB'(col_reg);
    assign pixel_y     = cursor_y_reg + CB'(row_reg);
    assign pixel_color = col_byte[row_reg] ? fg_reg : bg_reg;
    assign last_pixel  = stat.last;

    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        line_x_next   = line_x_reg;
        stopped_next  = stopped_reg;
        code_next     = code_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        glyph_next    = glyph_reg;
        row_next      = row_reg;
        col_next      = col_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                tgpg_pkg::REG_PANEL_WIDTH:  width_next  = cfg_data;
                tgpg_pkg::REG_PANEL_HEIGHT: height_next = cfg_data;
                default:                    width_next  = width_reg;
            endcase
        end

        if (cmd.load)
        begin
            code_next = char_code;
            fg_next   = fg_color;
            bg_next   = bg_color;
            if (new_string)
            begin
                cursor_x_next = start_x;
                line_x_next   = start_x;
                cursor_y_next = start_y;
                stopped_next  = 1'b0;
            end
        end

        if (cmd.line_feed)
        begin
            cursor_x_next = line_x_reg;
            cursor_y_next = y_sat;
        end

        if (cmd.set_stop)
        begin
            stopped_next = 1'b1;
        end

        if (cmd.latch_glyph)
        begin
            glyph_next = tgpg_pkg::GLYPH_ROM[tgpg_pkg::rom_index(code_reg)];
            row_next   = '0;
            col_next   = '0;
        end

        if (cmd.advance)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_reg + tgpg_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + tgpg_pkg::COL_BITS'(1);
            end
        end

        if (cmd.step_x)
        begin
            cursor_x_next = x_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= tgpg_pkg::PANEL_RESET;
            height_reg   <= tgpg_pkg::PANEL_RESET;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            line_x_reg   <= '0;
            stopped_reg  <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            line_x_reg   <= line_x_next;
            stopped_reg  <= stopped_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        fg_reg    <= fg_next;
        bg_reg    <= bg_next;
        glyph_reg <= glyph_next;
    end

endmodule

// ===== rtl/core/tgpg_ctrl.sv =====
// Controller state machine: sequences load, line checks and pixel emission.
// Talks to tgpg_datapath only through tgpg_pkg command and status structs.
module tgpg_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tgpg_pkg::tgpg_stat_t  stat,
    output tgpg_pkg::tgpg_cmd_t   cmd
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_HEIGHT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.stopped)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.is_newline)
                begin
                    cmd.line_feed = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.line_feed = stat.wrap;
                    state_next    = ST_HEIGHT;
                end
            end
            ST_HEIGHT:
            begin
                if (stat.too_tall)
                begin
                    cmd.set_stop = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.latch_glyph = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (stat.last)
                    begin
                        cmd.step_x = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/text_glyph_pixel_generator.sv =====
// Top level of the text glyph pixel generator.
// Joins tgpg_ctrl and tgpg_datapath; uses tgpg_pkg and the tgpg channel interfaces.
//
// Usage:
//   char_in  : one request per character byte with string start, colors and flags.
//   pixel_out: 48 pixel requests per drawn character, 6x8 cell in row-major order,
//              last_pixel high on the 48th.
//   cfg      : register writes, index 0 panel width, index 1 panel height; always
//              ready, to be written only while no character is in flight.
// Sequence:
//   After a character is accepted the block passes the check and height states before
//   the first pixel is offered; a drawn character then gives one pixel per cycle from
//   the cell counter while pixel_out.ready is high. Newlines and stopped characters
//   return to idle from check, dropped (too tall) ones from height; none give pixels.
//   One character is in flight at a time: char_in.ready is high only when idle.
// Reset:
//   Cursor, line start and stop flag clear; both panel registers return to 240.
// Stall:
//   While pixel_out.ready is low the current pixel and its coordinates hold.
module text_glyph_pixel_generator
(
    input logic          clk,
    input logic          rst_n,
    tgpg_in_if.sink      char_in,
    tgpg_out_if.source   pixel_out,
    tgpg_cfg_if.sink     cfg
);
    tgpg_pkg::tgpg_cmd_t  cmd;
    tgpg_pkg::tgpg_stat_t stat;
    logic                 in_ready;
    logic                 out_valid;

    assign cfg.ready       = 1'b1;
    assign char_in.ready   = in_ready;
    assign pixel_out.valid = out_valid;

    tgpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (char_in.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (pixel_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tgpg_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .char_code   (char_in.char_code),
        .new_string  (char_in.new_string),
        .start_x     (char_in.start_x),
        .start_y     (char_in.start_y),
        .fg_color    (char_in.fg_color),
        .bg_color    (char_in.bg_color),
        .cmd         (cmd),
        .stat        (stat),
        .pixel_x     (pixel_out.pixel_x),
        .pixel_y     (pixel_out.pixel_y),
        .pixel_color (pixel_out.pixel_color),
        .last_pixel  (pixel_out.last_pixel)
    );

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while pixels pending");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (char_in.valid && in_ready) |=> !in_ready && !out_valid)
        else $error("character not checked before emission");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_out.ready && pixel_out.last_pixel) |=> in_ready)
        else $error("block not idle after last pixel");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for text_glyph_pixel_generator: character requests in, pixel requests out.
// Predicts every pixel from its own cursor model and font table; depends on tgpg_pkg and
// the tgpg_in_if, tgpg_out_if and tgpg_cfg_if channel interfaces.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = tgpg_pkg::COORD_BITS;
    localparam int COORD_MAX = (1 << CW) - 1;
    localparam int CELL_COLS = 6;
    localparam int CELL_ROWS = 8;
    localparam int ROW_PITCH = 9;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_t;

    typedef struct packed {
        logic [7:0]    code;
        logic          new_string;
        logic [CW-1:0] start_x;
        logic [CW-1:0] start_y;
        logic [15:0]   fg;
        logic [15:0]   bg;
    } char_req_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [15:0]   color;
        logic          last;
    } pixel_t;

    // five column bytes per glyph, bit r of a byte is row r
    localparam logic [7:0] FONT_BYTES [425] = '{
        'h00,'h00,'h00,'h00,'h00, 'h00,'h00,'h5F,'h00,'h00, 'h00,'h07,'h00,'h07,'h00,
        'h14,'h7F,'h14,'h7F,'h14, 'h24,'h2A,'h7F,'h2A,'h12, 'h23,'h13,'h08,'h64,'h62,
        'h36,'h49,'h55,'h22,'h50, 'h00,'h05,'h03,'h00,'h00, 'h00,'h1C,'h22,'h41,'h00,
        'h00,'h41,'h22,'h1C,'h00, 'h14,'h08,'h3E,'h08,'h14, 'h08,'h08,'h3E,'h08,'h08,
        'h00,'h50,'h30,'h00,'h00, 'h08,'h08,'h08,'h08,'h08, 'h00,'h60,'h60,'h00,'h00,
        'h20,'h10,'h08,'h04,'h02, 'h3E,'h51,'h49,'h45,'h3E, 'h00,'h42,'h7F,'h40,'h00,
        'h42,'h61,'h51,'h49,'h46, 'h21,'h41,'h45,'h4B,'h31, 'h18,'h14,'h12,'h7F,'h10,
        'h27,'h45,'h45,'h45,'h39, 'h3C,'h4A,'h49,'h49,'h30, 'h01,'h71,'h09,'h05,'h03,
        'h36,'h49,'h49,'h49,'h36, 'h06,'h49,'h49,'h29,'h1E, 'h00,'h36,'h36,'h00,'h00,
        'h00,'h56,'h36,'h00,'h00, 'h08,'h14,'h22,'h41,'h00, 'h14,'h14,'h14,'h14,'h14,
        'h00,'h41,'h22,'h14,'h08, 'h02,'h01,'h51,'h09,'h06, 'h32,'h49,'h79,'h41,'h3E,
        'h7E,'h11,'h11,'h11,'h7E, 'h7F,'h49,'h49,'h49,'h36, 'h3E,'h41,'h41,'h41,'h22,
        'h7F,'h41,'h41,'h22,'h1C, 'h7F,'h49,'h49,'h49,'h41, 'h7F,'h09,'h09,'h09,'h01,
        'h3E,'h41,'h49,'h49,'h7A, 'h7F,'h08,'h08,'h08,'h7F, 'h00,'h41,'h7F,'h41,'h00,
        'h20,'h40,'h41,'h3F,'h01, 'h7F,'h08,'h14,'h22,'h41, 'h7F,'h40,'h40,'h40,'h40,
        'h7F,'h02,'h0C,'h02,'h7F, 'h7F,'h04,'h08,'h10,'h7F, 'h3E,'h41,'h41,'h41,'h3E,
        'h7F,'h09,'h09,'h09,'h06, 'h3E,'h41,'h51,'h21,'h5E, 'h7F,'h09,'h19,'h29,'h46,
        'h46,'h49,'h49,'h49,'h31, 'h01,'h01,'h7F,'h01,'h01, 'h3F,'h40,'h40,'h40,'h3F,
        'h1F,'h20,'h40,'h20,'h1F, 'h3F,'h40,'h38,'h40,'h3F, 'h63,'h14,'h08,'h14,'h63,
        'h07,'h08,'h70,'h08,'h07, 'h61,'h51,'h49,'h45,'h43, 'h20,'h54,'h54,'h54,'h78,
        'h7F,'h48,'h44,'h44,'h38, 'h38,'h44,'h44,'h44,'h20, 'h38,'h44,'h44,'h48,'h7F,
        'h38,'h54,'h54,'h54,'h18, 'h08,'h7E,'h09,'h01,'h02, 'h0C,'h52,'h52,'h52,'h3E,
        'h7F,'h08,'h04,'h04,'h78, 'h00,'h44,'h7D,'h40,'h00, 'h20,'h40,'h44,'h3D,'h00,
        'h7F,'h10,'h28,'h44,'h00, 'h00,'h41,'h7F,'h40,'h00, 'h7C,'h04,'h18,'h04,'h78,
        'h7C,'h08,'h04,'h04,'h78, 'h38,'h44,'h44,'h44,'h38, 'h7C,'h14,'h14,'h14,'h08,
        'h08,'h14,'h14,'h18,'h7C, 'h7C,'h08,'h04,'h04,'h08, 'h48,'h54,'h54,'h54,'h20,
        'h04,'h3F,'h44,'h40,'h20, 'h3C,'h40,'h40,'h20,'h7C, 'h1C,'h20,'h40,'h20,'h1C,
        'h3C,'h40,'h30,'h40,'h3C, 'h44,'h28,'h10,'h28,'h44, 'h0C,'h50,'h50,'h50,'h3C,
        'h44,'h64,'h54,'h4C,'h44
    };

    logic clk = 1'b0;
    logic rst_n;

    tgpg_in_if  char_if ();
    tgpg_out_if pix_if ();
    tgpg_cfg_if cfg_if ();

    text_glyph_pixel_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_if),
        .pixel_out (pix_if),
        .cfg       (cfg_if)
    );

    // text cursor and panel registers as the block should hold them
    logic [CW-1:0] cur_x;
    logic [CW-1:0] cur_y;
    logic [CW-1:0] line_x;
    logic          halted;
    logic [CW-1:0] panel_w;
    logic [CW-1:0] panel_h;

    char_req_t char_pending [$];
    pixel_t    px_expected [$];

    int req_sent;
    int req_done;
    int cfg_writes;
    int fail_count;
    int cycle_count;
    int src_idle_pct;
    int sink_stall_pct;
    bit hold_on;
    int hold_count;

    char_req_t next_req;
    char_req_t got_req;
    pixel_t    want_px;

    always #5 clk = ~clk;

    function automatic logic [CW-1:0] clamp_coord(int v);
        return (v > COORD_MAX) ? CW'(COORD_MAX) : CW'(v);
    endfunction

    function automatic int glyph_slot(logic [7:0] code);
        int c;
        c = int'(code);
        if (c < tgpg_pkg::CHAR_FIRST || c > tgpg_pkg::CHAR_LAST
            || (c >= tgpg_pkg::GAP_FIRST && c <= tgpg_pkg::GAP_LAST))
        begin
            c = int'(tgpg_pkg::CHAR_QMARK);
        end
        if (c >= tgpg_pkg::LOWER_FIRST)
        begin
            return c - int'(tgpg_pkg::LOWER_OFFSET);
        end
        return c - int'(tgpg_pkg::CHAR_FIRST);
    endfunction

    function automatic void line_feed();
        cur_x = line_x;
        cur_y = clamp_coord(int'(cur_y) + ROW_PITCH);
    endfunction

    function automatic void render_char(char_req_t r);
        int slot;
        logic [7:0] col_bits;
        pixel_t p;
        if (r.new_string)
        begin
            cur_x  = r.start_x;
            line_x = r.start_x;
            cur_y  = r.start_y;
            halted = 1'b0;
        end
        if (halted)
        begin
            return;
        end
        if (r.code == tgpg_pkg::CHAR_NEWLINE)
        begin
            line_feed();
            return;
        end
        if (int'(cur_x) + CELL_COLS > int'(panel_w))
        begin
            line_feed();
        end
        if (int'(cur_y) + CELL_ROWS > int'(panel_h))
        begin
            halted = 1'b1;
            return;
        end
        slot = glyph_slot(r.code);
        for (int row = 0; row < CELL_ROWS; row++)
        begin
            for (int col = 0; col < CELL_COLS; col++)
            begin
                col_bits = (col < 5) ? FONT_BYTES[slot * 5 + col] : 8'h00;
                p.x      = CW'(int'(cur_x) + col);
                p.y      = CW'(int'(cur_y) + row);
                p.color  = col_bits[row] ? r.fg : r.bg;
                p.last   = (row == CELL_ROWS - 1) && (col == CELL_COLS - 1);
                px_expected.push_back(p);
            end
        end
        cur_x = clamp_coord(int'(cur_x) + CELL_COLS);
    endfunction

    // sample all accepted requests at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == tgpg_pkg::REG_PANEL_WIDTH)
                begin
                    panel_w = cfg_if.data;
                end
                else if (cfg_if.index == tgpg_pkg::REG_PANEL_HEIGHT)
                begin
                    panel_h = cfg_if.data;
                end
                cfg_writes++;
            end
            if (char_if.valid && char_if.ready)
            begin
                got_req.code       = char_if.char_code;
                got_req.new_string = char_if.new_string;
                got_req.start_x    = char_if.start_x;
                got_req.start_y    = char_if.start_y;
                got_req.fg         = char_if.fg_color;
                got_req.bg         = char_if.bg_color;
                render_char(got_req);
                req_done++;
            end
            if (pix_if.valid && pix_if.ready)
            begin
                if (px_expected.size() == 0)
                begin
                    $error("pixel request with none expected: x=%0d y=%0d",
                           pix_if.pixel_x, pix_if.pixel_y);
                    fail_count++;
                end
                else
                begin
                    want_px = px_expected.pop_front();
                    if (pix_if.pixel_x !== want_px.x)
                    begin
                        $error("pixel_x expected %0d got %0d", want_px.x, pix_if.pixel_x);
                        fail_count++;
                    end
                    if (pix_if.pixel_y !== want_px.y)
                    begin
                        $error("pixel_y expected %0d got %0d", want_px.y, pix_if.pixel_y);
                        fail_count++;
                    end
                    if (pix_if.pixel_color !== want_px.color)
                    begin
                        $error("pixel_color expected %h got %h",
                               want_px.color, pix_if.pixel_color);
                        fail_count++;
                    end
                    if (pix_if.last_pixel !== want_px.last)
                    begin
                        $error("last_pixel expected %0d got %0d",
                               want_px.last, pix_if.last_pixel);
                        fail_count++;
                    end
                end
            end
        end
    end

    // character request driver
    always @(negedge clk)
    begin
        if (rst_n && (!char_if.valid || req_done == req_sent))
        begin
            if (char_pending.size() > 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                next_req = char_pending.pop_front();
                char_if.valid      <= 1'b1;
                char_if.char_code  <= next_req.code;
                char_if.new_string <= next_req.new_string;
                char_if.start_x    <= next_req.start_x;
                char_if.start_y    <= next_req.start_y;
                char_if.fg_color   <= next_req.fg;
                char_if.bg_color   <= next_req.bg;
                req_sent++;
            end
            else
            begin
                char_if.valid <= 1'b0;
            end
        end
    end

    // pixel receiver
    always @(negedge clk)
    begin
        if (hold_on && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            pix_if.ready <= 1'b0;
        end
        else
        begin
            pix_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_glyph_pixel_generator verification failed");
            $finish;
        end
    end

    task automatic push_char(bit ns, logic [7:0] code, int x, int y,
                             logic [15:0] fg, logic [15:0] bg);
        char_req_t r;
        r.code       = code;
        r.new_string = ns;
        r.start_x    = CW'(x);
        r.start_y    = CW'(y);
        r.fg         = fg;
        r.bg         = bg;
        char_pending.push_back(r);
    endtask

    function automatic logic [7:0] random_text();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            return 8'($urandom_range(tgpg_pkg::CHAR_FIRST, tgpg_pkg::CHAR_LAST));
        end
        if (pick == 8)
        begin
            return tgpg_pkg::CHAR_NEWLINE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly whole strings with random text, some loose noise requests
    task automatic push_random(int n);
        int added;
        int len;
        int sx;
        int sy;
        logic [15:0] fg;
        logic [15:0] bg;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                push_char(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                added++;
            end
            else
            begin
                len = $urandom_range(2, 10);
                fg  = 16'($urandom_range(0, 65535));
                bg  = 16'($urandom_range(0, 65535));
                sx  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, COORD_MAX)
                                                  : $urandom_range(0, panel_w);
                sy  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, COORD_MAX)
                                                  : $urandom_range(0, panel_h);
                push_char(1'b1, random_text(), sx, sy, fg, bg);
                for (int i = 1; i < len; i++)
                begin
                    push_char(1'b0, random_text(), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), fg, bg);
                end
                added += len;
            end
        end
    endtask

    task automatic write_panel(int w, int h);
        int target;
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = tgpg_pkg::REG_PANEL_WIDTH;
        cfg_if.data  = CW'(w);
        target = cfg_writes + 1;
        do @(negedge clk); while (cfg_writes < target);
        cfg_if.index = tgpg_pkg::REG_PANEL_HEIGHT;
        cfg_if.data  = CW'(h);
        target = cfg_writes + 1;
        do @(negedge clk); while (cfg_writes < target);
        cfg_if.valid = 1'b0;
    endtask

    // run the queued requests under one flow pattern and wait for the block to go idle
    task automatic play(flow_mode_t mode);
        src_idle_pct   = (mode == FLOW_SRC_IDLE) ? 85 : (mode == FLOW_BOTH) ? 8 : 0;
        sink_stall_pct = (mode == FLOW_SINK_STALL) ? 85 : (mode == FLOW_BOTH) ? 8 : 0;
        while (char_pending.size() != 0 || req_done != req_sent)
        begin
            @(posedge clk);
        end
        while (px_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        char_if.valid      = 1'b0;
        char_if.char_code  = '0;
        char_if.new_string = 1'b0;
        char_if.start_x    = '0;
        char_if.start_y    = '0;
        char_if.fg_color   = '0;
        char_if.bg_color   = '0;
        pix_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        cur_x = '0;
        cur_y = '0;
        line_x = '0;
        halted = 1'b0;
        panel_w = CW'(240);
        panel_h = CW'(240);
        req_sent = 0;
        req_done = 0;
        cfg_writes = 0;
        fail_count = 0;
        cycle_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_on = 1'b0;
        hold_count = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset panel size: glyph mapping, wrap, stop and saturation
        push_char(1, 8'h41, 0, 0, 16'hFFFF, 16'h0000);
        push_char(0, 8'h00, 0, 0, 16'h0000, 16'hFFFF);
        push_char(0, 8'hFF, 0, 0, 16'hFFFF, 16'h0000);
        push_char(0, 8'h20, 0, 0, 16'hA5A5, 16'h5A5A);
        push_char(0, 8'h7A, 0, 0, 16'h5A5A, 16'hA5A5);
        push_char(0, 8'h5B, 0, 0, 16'hFFFF, 16'h0000);
        push_char(0, 8'h60, 0, 0, 16'hFFFF, 16'h0000);
        push_char(0, 8'h7B, 0, 0, 16'hFFFF, 16'h0000);
        push_char(0, tgpg_pkg::CHAR_NEWLINE, 0, 0, 16'hFFFF, 16'h0000);
        push_char(1, 8'h42, 234, 0, 16'h1234, 16'hFEDC);
        push_char(0, 8'h43, 0, 0, 16'h1234, 16'hFEDC);
        push_char(1, 8'h44, 0, 232, 16'hF800, 16'h07E0);
        push_char(0, tgpg_pkg::CHAR_NEWLINE, 0, 0, 16'hF800, 16'h07E0);
        push_char(0, 8'h45, 0, 0, 16'hF800, 16'h07E0);
        push_char(0, 8'h46, 0, 0, 16'hF800, 16'h07E0);
        push_char(0, tgpg_pkg::CHAR_NEWLINE, 0, 0, 16'hF800, 16'h07E0);
        push_char(1, tgpg_pkg::CHAR_NEWLINE, 10, 10, 16'h001F, 16'hFFE0);
        push_char(0, 8'h47, 0, 0, 16'h001F, 16'hFFE0);
        push_char(1, 8'h48, COORD_MAX, COORD_MAX, 16'hFFFF, 16'h0000);
        play(FLOW_FREE);

        // widest and tallest panel: x wrap of pixels and cursor saturation
        write_panel(COORD_MAX, COORD_MAX);
        push_char(1, 8'h49, 1020, 1000, 16'hFFFF, 16'h0000);
        push_char(0, 8'h4A, 0, 0, 16'hFFFF, 16'h0000);
        push_char(1, 8'h4B, 0, 1015, 16'h0000, 16'hFFFF);
        push_char(0, tgpg_pkg::CHAR_NEWLINE, 0, 0, 16'h0000, 16'hFFFF);
        push_char(0, 8'h4C, 0, 0, 16'h0000, 16'hFFFF);
        push_char(1, 8'h7A, 1017, 0, 16'hAAAA, 16'h5555);
        play(FLOW_FREE);

        // one pixel wide panel: every cell wraps
        write_panel(1, COORD_MAX);
        push_char(1, 8'h4E, 0, 0, 16'hFFFF, 16'h0000);
        push_char(0, 8'h4F, 0, 0, 16'hFFFF, 16'h0000);
        push_char(1, 8'h50, COORD_MAX, 5, 16'hFFFF, 16'h0000);
        push_random(10);
        play(FLOW_SRC_IDLE);

        // hold the pixel side off while requests keep coming
        write_panel(240, 240);
        hold_on = 1'b1;
        push_random(20);
        play(FLOW_SINK_STALL);

        write_panel($urandom_range(6, COORD_MAX), $urandom_range(8, COORD_MAX));
        push_random(20);
        play(FLOW_BOTH);

        write_panel(COORD_MAX, 1);
        push_char(1, 8'h51, 0, 0, 16'hFFFF, 16'h0000);
        push_random(5);
        play(FLOW_FREE);

        write_panel($urandom_range(100, COORD_MAX), $urandom_range(100, COORD_MAX));
        push_random(10);
        play(FLOW_FREE);

        if (fail_count == 0)
        begin
            $display("text_glyph_pixel_generator verification clean");
        end
        else
        begin
            $display("text_glyph_pixel_generator verification failed");
        end
        $finish;
    end

endmodule
